[hdl/lpmr_pkg.sv]
// Shared types and constants for the length-prefixed message ring.
`default_nettype none

package lpmr_pkg;

    localparam int RING_DEPTH_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 4;
    localparam int RING_BYTES_RESET = 4096;
    localparam int MIN_RING         = 8;

    localparam int CFG_W       = 13;
    localparam int LEN_W       = 16;
    localparam int COUNT_W     = 16;
    localparam int HLEN_W      = 32;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 64;

    localparam logic [1:0] K_PUSH_HDR  = 2'd0;
    localparam logic [1:0] K_PUSH_BYTE = 2'd1;
    localparam logic [1:0] K_POP_START = 2'd2;
    localparam logic [1:0] K_POP_BYTE  = 2'd3;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_BADLEN = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_BEYOND = 3'd4;
    localparam logic [2:0] ST_DROP   = 3'd5;

    typedef enum logic [2:0] {
        C_NONE      = 3'd0,
        C_PUSH_HDR  = 3'd1,
        C_PUSH_BYTE = 3'd2,
        C_POP_START = 3'd3,
        C_POP_BYTE  = 3'd4,
        C_HDR_STEP  = 3'd5,
        C_POP_CHECK = 3'd6,
        C_POP_OUT   = 3'd7
    } t_cmd;

    typedef struct packed {
        logic out_busy;
        logic empty;
        logic pop_open;
        logic hdr_last;
    } t_dp_sts;

endpackage

`default_nettype wire

[hdl/lpmr_ctrl.sv]
// Controller state machine: sequences item handling and header reads.
`default_nettype none

module lpmr_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_valid,
    input  wire logic [1:0]            i_kind,
    input  wire lpmr_pkg::t_dp_sts     i_sts,
    output logic                       o_s_ready,
    output lpmr_pkg::t_cmd             o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_RDBYTE = 5'b00010,
        S_HDR    = 5'b00100,
        S_HDRW   = 5'b01000,
        S_CHECK  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state   = r_state;
        o_s_ready = 1'b0;
        o_cmd     = lpmr_pkg::C_NONE;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = !i_sts.out_busy;
                if (i_s_valid && !i_sts.out_busy) begin
                    unique case (i_kind)
                        lpmr_pkg::K_PUSH_HDR: begin
                            o_cmd = lpmr_pkg::C_PUSH_HDR;
                        end
                        lpmr_pkg::K_PUSH_BYTE: begin
                            o_cmd = lpmr_pkg::C_PUSH_BYTE;
                        end
                        lpmr_pkg::K_POP_START: begin
                            o_cmd = lpmr_pkg::C_POP_START;
                            if (!i_sts.empty) begin
                                n_state = S_HDR;
                            end
                        end
                        lpmr_pkg::K_POP_BYTE: begin
                            o_cmd = lpmr_pkg::C_POP_BYTE;
                            if (i_sts.pop_open) begin
                                n_state = S_RDBYTE;
                            end
                        end
                    endcase
                end
            end
            S_RDBYTE: begin
                o_cmd   = lpmr_pkg::C_POP_OUT;
                n_state = S_IDLE;
            end
            S_HDR: begin
                o_cmd = lpmr_pkg::C_HDR_STEP;
                if (i_sts.hdr_last) begin
                    n_state = S_HDRW;
                end
            end
            S_HDRW: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                o_cmd   = lpmr_pkg::C_POP_CHECK;
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[hdl/lpmr_dp.sv]
// Datapath: ring memory, pointers, counters, header parse and result register.
`default_nettype none

module lpmr_dp #(
    parameter int RING_DEPTH   = lpmr_pkg::RING_DEPTH_DEF,
    parameter int HEADER_BYTES = lpmr_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lpmr_pkg::t_cmd                      i_cmd,
    input  wire logic                                i_cfg_we,
    input  wire logic [lpmr_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic [lpmr_pkg::LEN_W-1:0]          i_msg_length,
    input  wire logic [7:0]                          i_data_byte,
    input  wire logic                                i_m_ready,
    output lpmr_pkg::t_dp_sts                        o_sts,
    output logic                                     o_m_valid,
    output logic [lpmr_pkg::OUT_TDATA_W-1:0]         o_m_data,
    output logic                                     o_m_last
);

    localparam int PW  = $clog2(RING_DEPTH + 1);
    localparam int AW  = $clog2(RING_DEPTH);
    localparam int HW  = HEADER_BYTES * 8;
    localparam int IW  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    localparam int SW  = ((PW > lpmr_pkg::LEN_W) ? PW : lpmr_pkg::LEN_W) + 1;
    localparam int VW0 = (HW > lpmr_pkg::HLEN_W) ? HW : lpmr_pkg::HLEN_W;
    localparam int VW  = (VW0 > PW) ? VW0 : PW;
    localparam int CW  = (PW > lpmr_pkg::CFG_W) ? PW : lpmr_pkg::CFG_W;
    localparam int RESET_R = (lpmr_pkg::RING_BYTES_RESET > RING_DEPTH) ?
                             RING_DEPTH : lpmr_pkg::RING_BYTES_RESET;
    localparam int PAD_W = lpmr_pkg::OUT_TDATA_W - 3 - 8 - lpmr_pkg::HLEN_W
                           - lpmr_pkg::COUNT_W;

    logic [7:0] mem [RING_DEPTH];

    logic [PW-1:0]                  r_ring, n_ring;
    logic [PW-1:0]                  r_wp, n_wp;
    logic [PW-1:0]                  r_rp, n_rp;
    logic [PW-1:0]                  r_cursor, n_cursor;
    logic [lpmr_pkg::COUNT_W-1:0]   r_count, n_count;
    logic [PW-1:0]                  r_push_rem, n_push_rem;
    logic [PW-1:0]                  r_pop_rem, n_pop_rem;
    logic [IW-1:0]                  r_hidx, n_hidx;
    logic                           r_hdr_rd, n_hdr_rd;
    logic                           r_last_pend, n_last_pend;
    logic                           r_out_valid, n_out_valid;
    logic [HW-1:0]                  r_v;
    logic [7:0]                     r_rdata;
    logic [2:0]                     r_out_status;
    logic [7:0]                     r_out_byte;
    logic [lpmr_pkg::HLEN_W-1:0]    r_out_hlen;
    logic                           r_out_last;
    logic [lpmr_pkg::COUNT_W-1:0]   r_out_count;

    logic [CW-1:0]                  cfg_ext;
    logic [PW-1:0]                  cfg_ring;
    logic [PW-1:0]                  cur_wrap;
    logic [PW-1:0]                  cur_next;
    logic [PW:0]                    hsum;
    logic [PW:0]                    hwrap;
    logic [AW-1:0]                  rd_addr;
    logic [SW-1:0]                  size_ext, ring_ext, w_ext, rd_ext, push_pos;
    logic                           oversize, full;
    logic [VW-1:0]                  v_ext;
    logic                           neg, big, beyond;
    logic [PW-1:0]                  pop_size;
    logic [PW:0]                    pop_pos;
    logic                           empty;
    logic                           load, mem_we;
    logic [2:0]                     ld_status;
    logic [7:0]                     ld_byte;
    logic [lpmr_pkg::HLEN_W-1:0]    ld_hlen;
    logic                           ld_last;

    // register write value clamped to the usable range
    always_comb begin
        cfg_ext = CW'(i_cfg_data);
        if (cfg_ext > CW'(RING_DEPTH)) begin
            cfg_ring = PW'(RING_DEPTH);
        end else if (cfg_ext < CW'(lpmr_pkg::MIN_RING)) begin
            cfg_ring = PW'(lpmr_pkg::MIN_RING);
        end else begin
            cfg_ring = cfg_ext[PW-1:0];
        end
    end

    assign cur_wrap = (r_cursor >= r_ring) ? r_cursor - r_ring : r_cursor;
    assign cur_next = cur_wrap + PW'(1);

    assign hsum    = {1'b0, r_rp} + (PW+1)'(r_hidx);
    assign hwrap   = (hsum >= {1'b0, r_ring}) ? hsum - {1'b0, r_ring} : hsum;
    assign rd_addr = (i_cmd == lpmr_pkg::C_HDR_STEP) ? hwrap[AW-1:0] : cur_wrap[AW-1:0];

    // push header room check
    assign size_ext = SW'(i_msg_length);
    assign ring_ext = SW'(r_ring);
    assign w_ext    = SW'(r_wp);
    assign rd_ext   = SW'(r_rp);
    assign push_pos = w_ext + size_ext;
    assign oversize = size_ext > ring_ext;
    assign full     = (r_wp >= r_rp) ?
                      ((push_pos > ring_ext) && (push_pos >= ring_ext + rd_ext)) :
                      (push_pos >= rd_ext);

    // parsed length checks
    assign v_ext    = VW'(r_v);
    assign neg      = r_v[HW-1];
    assign big      = v_ext > VW'(r_ring);
    assign pop_size = v_ext[PW-1:0];
    assign pop_pos  = {1'b0, r_rp} + {1'b0, pop_size};
    assign beyond   = (r_rp < r_wp) ? (pop_pos > {1'b0, r_wp}) :
                      ((pop_pos > {1'b0, r_ring}) &&
                       (pop_pos > {1'b0, r_ring} + {1'b0, r_wp}));

    assign empty = (r_count == '0) || (r_rp == r_wp);

    always_comb begin
        n_ring      = r_ring;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_cursor    = r_cursor;
        n_count     = r_count;
        n_push_rem  = r_push_rem;
        n_pop_rem   = r_pop_rem;
        n_hidx      = r_hidx;
        n_hdr_rd    = 1'b0;
        n_last_pend = r_last_pend;
        n_out_valid = r_out_valid && !i_m_ready;
        load        = 1'b0;
        mem_we      = 1'b0;
        ld_status   = lpmr_pkg::ST_OK;
        ld_byte     = '0;
        ld_hlen     = '0;
        ld_last     = 1'b0;
        unique case (i_cmd)
            lpmr_pkg::C_NONE: begin
            end
            lpmr_pkg::C_PUSH_HDR: begin
                load       = 1'b1;
                n_push_rem = '0;
                n_pop_rem  = '0;
                if (oversize) begin
                    ld_status = lpmr_pkg::ST_BADLEN;
                end else if (full) begin
                    ld_status = lpmr_pkg::ST_FULL;
                end else if (i_msg_length == '0) begin
                    n_count = r_count + 1'b1;
                end else begin
                    n_push_rem = PW'(i_msg_length);
                    n_cursor   = r_wp;
                end
            end
            lpmr_pkg::C_PUSH_BYTE: begin
                load = 1'b1;
                if (r_push_rem == '0) begin
                    ld_status = lpmr_pkg::ST_DROP;
                end else begin
                    mem_we     = 1'b1;
                    n_cursor   = cur_next;
                    n_push_rem = r_push_rem - 1'b1;
                    if (r_push_rem == PW'(1)) begin
                        n_wp    = cur_next;
                        n_count = r_count + 1'b1;
                        ld_last = 1'b1;
                    end
                end
            end
            lpmr_pkg::C_POP_START: begin
                n_push_rem = '0;
                n_pop_rem  = '0;
                n_hidx     = '0;
                if (empty) begin
                    load      = 1'b1;
                    ld_status = lpmr_pkg::ST_EMPTY;
                end
            end
            lpmr_pkg::C_POP_BYTE: begin
                if (r_pop_rem == '0) begin
                    load      = 1'b1;
                    ld_status = lpmr_pkg::ST_DROP;
                end else begin
                    n_cursor    = cur_next;
                    n_pop_rem   = r_pop_rem - 1'b1;
                    n_last_pend = (r_pop_rem == PW'(1));
                    if (r_pop_rem == PW'(1)) begin
                        n_rp    = cur_next;
                        n_count = r_count - 1'b1;
                    end
                end
            end
            lpmr_pkg::C_HDR_STEP: begin
                n_hidx   = r_hidx + 1'b1;
                n_hdr_rd = 1'b1;
            end
            lpmr_pkg::C_POP_CHECK: begin
                load    = 1'b1;
                ld_hlen = v_ext[lpmr_pkg::HLEN_W-1:0];
                if (neg || big) begin
                    ld_status = lpmr_pkg::ST_BADLEN;
                end else if (beyond) begin
                    ld_status = lpmr_pkg::ST_BEYOND;
                end else if (pop_size == '0) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_pop_rem = pop_size;
                    n_cursor  = r_rp;
                end
            end
            lpmr_pkg::C_POP_OUT: begin
                load    = 1'b1;
                ld_byte = r_rdata;
                ld_last = r_last_pend;
            end
        endcase
        if (load) begin
            n_out_valid = 1'b1;
        end
        if (i_cfg_we) begin
            n_ring     = cfg_ring;
            n_wp       = '0;
            n_rp       = '0;
            n_cursor   = '0;
            n_count    = '0;
            n_push_rem = '0;
            n_pop_rem  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring      <= PW'(RESET_R);
            r_wp        <= '0;
            r_rp        <= '0;
            r_cursor    <= '0;
            r_count     <= '0;
            r_push_rem  <= '0;
            r_pop_rem   <= '0;
            r_hidx      <= '0;
            r_hdr_rd    <= 1'b0;
            r_last_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ring      <= n_ring;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_cursor    <= n_cursor;
            r_count     <= n_count;
            r_push_rem  <= n_push_rem;
            r_pop_rem   <= n_pop_rem;
            r_hidx      <= n_hidx;
            r_hdr_rd    <= n_hdr_rd;
            r_last_pend <= n_last_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // header bytes arrive in the cycle after their read, big-endian
    always_ff @(posedge i_clk) begin
        if (r_hdr_rd) begin
            r_v <= HW'({r_v, r_rdata});
        end
        if (load) begin
            r_out_status <= ld_status;
            r_out_byte   <= ld_byte;
            r_out_hlen   <= ld_hlen;
            r_out_last   <= ld_last;
            r_out_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[cur_wrap[AW-1:0]] <= i_data_byte;
        end
        r_rdata <= mem[rd_addr];
    end

    assign o_sts.out_busy = r_out_valid && !i_m_ready;
    assign o_sts.empty    = empty;
    assign o_sts.pop_open = (r_pop_rem != '0);
    assign o_sts.hdr_last = (r_hidx == IW'(HEADER_BYTES - 1));

    assign o_m_valid = r_out_valid;
    assign o_m_last  = r_out_last;
    assign o_m_data  = {{PAD_W{1'b0}}, r_out_count, r_out_hlen, r_out_byte, r_out_status};

endmodule

`default_nettype wire

[hdl/length_prefixed_message_ring.sv]
// Top level of the length-prefixed message ring.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: msg_length, data_byte; tuser: kind
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: status, read_byte, header_length,
//                                                message_count; tlast: last_byte
//  cfg       in   i_cfg_we                       i_cfg_data: ring_bytes
//
//  Push header, push byte and stray bytes are handled without leaving the idle state.
//  Pop byte: the byte comes through the registered read of the ring memory (S_RDBYTE).
//  Pop start: an EMPTY result from the idle state when empty, else one header byte read
//  per cycle through the single read port (S_HDR), then S_HDRW and a length check (S_CHECK).
//  Reset is synchronous and clears all control state at once; no clearing pass.
//  An item is taken only while the result register is empty or being drained.
`default_nettype none

module length_prefixed_message_ring #(
    parameter int RING_DEPTH   = lpmr_pkg::RING_DEPTH_DEF,
    parameter int HEADER_BYTES = lpmr_pkg::HEADER_BYTES_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lpmr_pkg::CFG_W-1:0]        i_cfg_data,     // ring_bytes
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [lpmr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,   // msg_length, data_byte
    input  wire logic [1:0]                        s_axis_tuser,   // kind
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [lpmr_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,   // status, read_byte,
                                                                   // header_length,
                                                                   // message_count, pad
    output logic                                   m_axis_tlast
);

    lpmr_pkg::t_cmd    cmd;
    lpmr_pkg::t_dp_sts sts;

    lpmr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_kind    (s_axis_tuser),
        .i_sts     (sts),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    lpmr_dp #(
        .RING_DEPTH   (RING_DEPTH),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_msg_length (s_axis_tdata[15:0]),
        .i_data_byte  (s_axis_tdata[23:16]),
        .i_m_ready    (m_axis_tready),
        .o_sts        (sts),
        .o_m_valid    (m_axis_tvalid),
        .o_m_data     (m_axis_tdata),
        .o_m_last     (m_axis_tlast)
    );

    a_last_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[2:0] == lpmr_pkg::ST_OK))
        else $error("last item with non-ok status");

    a_hdr_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == lpmr_pkg::K_PUSH_HDR))
        |=> m_axis_tvalid)
        else $error("push header gave no result");

    a_no_take_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(m_axis_tvalid && !m_axis_tready))
        else $error("item taken while result stalled");

    a_empty_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[2:0] == lpmr_pkg::ST_EMPTY))
        |-> (m_axis_tdata[42:11] == 32'd0))
        else $error("empty result carries a length");

endmodule

`default_nettype wire
